[rtl/fcrq_pkg.sv]
// Shared constants, field widths and codes for the int8 fully connected block.
package fcrq_pkg;

   localparam int HIDDEN_MAX = 256;
   localparam int OUT_MAX    = 64;
   localparam int FRAC_BITS  = 24;

   localparam int WSTORE_DEPTH = HIDDEN_MAX * OUT_MAX;
   localparam int WADDR_W      = $clog2(WSTORE_DEPTH);
   localparam int ROW_AW       = $clog2(HIDDEN_MAX);
   localparam int HID_W        = $clog2(HIDDEN_MAX + 1);
   localparam int CH_W         = $clog2(OUT_MAX);
   localparam int OUTC_W       = $clog2(OUT_MAX + 1);

   localparam int IDX_W   = 14;
   localparam int BYTE_W  = 8;
   localparam int WORD_W  = 32;
   localparam int PROD_W  = 2 * WORD_W;
   localparam int MAC_W   = 2 * BYTE_W;

   localparam int REQ_DATA_W = 88;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD_W  = RSP_DATA_W - BYTE_W - 6;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   // Request kinds carried on req_tuser
   localparam logic [1:0] REQ_WEIGHT = 2'd0;
   localparam logic [1:0] REQ_BIAS   = 2'd1;
   localparam logic [1:0] REQ_MULT   = 2'd2;
   localparam logic [1:0] REQ_ACT    = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HIDDEN_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_COUNT   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSPOSED  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BIAS_ENABLE = 2'd3;

   localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [PROD_W-1:0] CLAMP_MAX  = PROD_W'(127);

endpackage

[rtl/fully_connected_int8_requant_top.sv]
// Top level of the int8 fully connected layer with per-channel requantization.
// Write items (weight, bias, multiplier) and activations that do not finish a
// row are absorbed without leaving the idle state. The activation that finishes a row starts the MAC
// sequencer: one shared 8x8 multiply-accumulate walks the row buffer and the
// weight store, both single-port synchronous memories read one entry a cycle,
// so each output channel takes a walk over hidden_len elements plus setup,
// pipeline drain and the 32x32 requant multiply; req_tready stays low until
// the whole row is done. Results leave through a one-deep output register, so
// the block is ready for new items while the last result of a row still waits.
// A stalled output stalls the sequencer. Weight layout follows weight_transposed:
// row-major (channel * hidden_len + element) or transposed
// (channel + element * out_count). Registers must be written only while the
// block is idle; the block itself does not enforce this.
module fully_connected_int8_requant_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // index[13:0], byte_value[21:14], bias_value[53:22], mult_value[85:54], zero pad
   input  logic [fcrq_pkg::REQ_DATA_W-1:0]   req_tdata,
   // req_type[1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_value[7:0], channel[13:8], zero pad
   output logic [fcrq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  logic [fcrq_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [fcrq_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_MAC   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_MUL   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   // Configuration registers
   logic [fcrq_pkg::HID_W-1:0]  hidden_len_ff;
   logic [fcrq_pkg::OUTC_W-1:0] out_count_ff;
   logic                        transposed_ff;
   logic                        bias_en_ff;

   // Storage
   logic signed [fcrq_pkg::BYTE_W-1:0] weight_mem [fcrq_pkg::WSTORE_DEPTH];
   logic signed [fcrq_pkg::BYTE_W-1:0] row_mem    [fcrq_pkg::HIDDEN_MAX];
   logic [fcrq_pkg::WORD_W-1:0]        bias_mem   [fcrq_pkg::OUT_MAX];
   logic [fcrq_pkg::WORD_W-1:0]        mult_mem   [fcrq_pkg::OUT_MAX];

   logic signed [fcrq_pkg::BYTE_W-1:0] weight_q_ff;
   logic signed [fcrq_pkg::BYTE_W-1:0] row_q_ff;
   logic [fcrq_pkg::WORD_W-1:0]        bias_q_ff;
   logic [fcrq_pkg::WORD_W-1:0]        mult_q_ff;

   // Sequencer
   logic [2:0]                     state_ff;
   logic [fcrq_pkg::ROW_AW-1:0]    cnt_ff;
   logic [fcrq_pkg::ROW_AW-1:0]    e_ff;
   logic [fcrq_pkg::CH_W-1:0]      ch_ff;
   logic [fcrq_pkg::WADDR_W-1:0]   base_ff;
   logic [fcrq_pkg::WADDR_W-1:0]   waddr_ff;

   // MAC pipeline
   logic                              rd_v_ff;
   logic                              prod_v_ff;
   logic signed [fcrq_pkg::MAC_W-1:0] prod_ff;
   logic [fcrq_pkg::WORD_W-1:0]       acc_ff;

   // Output register
   logic                              rsp_valid_ff;
   logic signed [fcrq_pkg::BYTE_W-1:0] rsp_value_ff;
   logic [fcrq_pkg::CH_W-1:0]         rsp_ch_ff;
   logic                              rsp_last_ff;

   // Request fields
   logic [fcrq_pkg::IDX_W-1:0]         req_index;
   logic signed [fcrq_pkg::BYTE_W-1:0] req_byte;
   logic [fcrq_pkg::WORD_W-1:0]        req_bias;
   logic [fcrq_pkg::WORD_W-1:0]        req_mult;
   logic                               req_fire;

   logic [fcrq_pkg::HID_W-1:0]    hid_eff;
   logic [fcrq_pkg::OUTC_W-1:0]   outs_eff;
   logic [fcrq_pkg::HID_W-1:0]    cnt_next;
   logic                          row_done;
   logic                          elem_last;
   logic                          ch_last;
   logic [fcrq_pkg::WADDR_W-1:0]  waddr_step;
   logic [fcrq_pkg::WADDR_W-1:0]  base_next;
   logic                          out_load;
   logic signed [fcrq_pkg::BYTE_W-1:0] rq_value;

   assign req_index = req_tdata[13:0];
   assign req_byte  = req_tdata[21:14];
   assign req_bias  = req_tdata[53:22];
   assign req_mult  = req_tdata[85:54];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // Saturate register values to the supported ranges
   always_comb begin
      if (hidden_len_ff == '0) begin
         hid_eff = fcrq_pkg::HID_W'(1);
      end else if (hidden_len_ff > fcrq_pkg::HID_W'(fcrq_pkg::HIDDEN_MAX)) begin
         hid_eff = fcrq_pkg::HID_W'(fcrq_pkg::HIDDEN_MAX);
      end else begin
         hid_eff = hidden_len_ff;
      end
      if (out_count_ff == '0) begin
         outs_eff = fcrq_pkg::OUTC_W'(1);
      end else if (out_count_ff > fcrq_pkg::OUTC_W'(fcrq_pkg::OUT_MAX)) begin
         outs_eff = fcrq_pkg::OUTC_W'(fcrq_pkg::OUT_MAX);
      end else begin
         outs_eff = out_count_ff;
      end
   end

   assign cnt_next   = fcrq_pkg::HID_W'(cnt_ff) + 1'b1;
   assign row_done   = (cnt_next >= hid_eff);
   assign elem_last  = (fcrq_pkg::HID_W'(e_ff) + 1'b1) == hid_eff;
   assign ch_last    = (fcrq_pkg::OUTC_W'(ch_ff) + 1'b1) == outs_eff;
   assign waddr_step = transposed_ff ? fcrq_pkg::WADDR_W'(outs_eff) : fcrq_pkg::WADDR_W'(1);
   assign base_next  = transposed_ff ? (fcrq_pkg::WADDR_W'(ch_ff) + 1'b1)
                                     : (base_ff + fcrq_pkg::WADDR_W'(hid_eff));
   assign out_load   = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_tready);

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         hidden_len_ff <= fcrq_pkg::HID_W'(1);
         out_count_ff  <= fcrq_pkg::OUTC_W'(1);
         transposed_ff <= 1'b0;
         bias_en_ff    <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            fcrq_pkg::CSR_HIDDEN_LEN:  hidden_len_ff <= csr_wdata[fcrq_pkg::HID_W-1:0];
            fcrq_pkg::CSR_OUT_COUNT:   out_count_ff  <= csr_wdata[fcrq_pkg::OUTC_W-1:0];
            fcrq_pkg::CSR_TRANSPOSED:  transposed_ff <= csr_wdata[0];
            fcrq_pkg::CSR_BIAS_ENABLE: bias_en_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Memory write ports: load items, and activations into the row buffer
   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == fcrq_pkg::REQ_WEIGHT) begin
         weight_mem[req_index[fcrq_pkg::WADDR_W-1:0]] <= req_byte;
      end
      if (req_fire && req_tuser == fcrq_pkg::REQ_ACT) begin
         row_mem[cnt_ff] <= req_byte;
      end
      if (req_fire && req_tuser == fcrq_pkg::REQ_BIAS &&
          req_index < fcrq_pkg::IDX_W'(fcrq_pkg::OUT_MAX)) begin
         bias_mem[req_index[fcrq_pkg::CH_W-1:0]] <= req_bias;
      end
      if (req_fire && req_tuser == fcrq_pkg::REQ_MULT &&
          req_index < fcrq_pkg::IDX_W'(fcrq_pkg::OUT_MAX)) begin
         mult_mem[req_index[fcrq_pkg::CH_W-1:0]] <= req_mult;
      end
   end

   // Registered read ports; per-channel data follows ch_ff
   always_ff @(posedge clock) begin
      weight_q_ff <= weight_mem[waddr_ff];
      row_q_ff    <= row_mem[e_ff];
      bias_q_ff   <= bias_mem[ch_ff];
      mult_q_ff   <= mult_mem[ch_ff];
   end

   // Row sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire && req_tuser == fcrq_pkg::REQ_ACT) begin
                  if (row_done) begin
                     cnt_ff   <= '0;
                     ch_ff    <= '0;
                     base_ff  <= '0;
                     state_ff <= S_START;
                  end else begin
                     cnt_ff <= cnt_next[fcrq_pkg::ROW_AW-1:0];
                  end
               end
            end
            S_START: begin
               // bias and multiplier reads for ch_ff land during this cycle
               waddr_ff <= base_ff;
               e_ff     <= '0;
               state_ff <= S_MAC;
            end
            S_MAC: begin
               waddr_ff <= waddr_ff + waddr_step;
               e_ff     <= e_ff + 1'b1;
               if (elem_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (!rd_v_ff && !prod_v_ff) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_load) begin
                  if (ch_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     ch_ff    <= ch_ff + 1'b1;
                     base_ff  <= base_next;
                     state_ff <= S_START;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // MAC pipeline: read, multiply, accumulate
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff   <= (state_ff == S_MAC);
         prod_v_ff <= rd_v_ff;
      end
      prod_ff <= row_q_ff * weight_q_ff;
      if (state_ff == S_MAC && e_ff == '0) begin
         // seed the channel before its first product arrives
         acc_ff <= bias_en_ff ? bias_q_ff : '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + fcrq_pkg::WORD_W'(prod_ff);
      end
   end

   fcrq_requant u_requant (
      .clock      (clock),
      .acc_value  (acc_ff),
      .mult_value (mult_q_ff),
      .out_value  (rq_value)
   );

   // Output register: hold until taken, load the next channel result
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (out_load) begin
         rsp_value_ff <= rq_value;
         rsp_ch_ff    <= ch_ff;
         rsp_last_ff  <= ch_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{fcrq_pkg::RSP_PAD_W{1'b0}}, rsp_ch_ff, rsp_value_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[rtl/fcrq_requant.sv]
// Requantizer: sign-magnitude scale multiply, round half away from zero, clamp.
module fcrq_requant (
   input  logic                        clock,
   input  logic [fcrq_pkg::WORD_W-1:0] acc_value,
   input  logic [fcrq_pkg::WORD_W-1:0] mult_value,
   output logic signed [fcrq_pkg::BYTE_W-1:0] out_value
);

   logic [fcrq_pkg::WORD_W-1:0] mag;
   logic [fcrq_pkg::PROD_W-1:0] prod_ff;
   logic                        neg_ff;
   logic [fcrq_pkg::PROD_W-1:0] rounded;
   logic [fcrq_pkg::PROD_W-1:0] shifted;
   logic [fcrq_pkg::BYTE_W-1:0] mag8;

   assign mag = acc_value[fcrq_pkg::WORD_W-1] ? (~acc_value + 1'b1) : acc_value;

   always_ff @(posedge clock) begin
      prod_ff <= fcrq_pkg::PROD_W'(mag) * fcrq_pkg::PROD_W'(mult_value);
      neg_ff  <= acc_value[fcrq_pkg::WORD_W-1];
   end

   always_comb begin
      rounded   = prod_ff + fcrq_pkg::ROUND_HALF;
      shifted   = rounded >> fcrq_pkg::FRAC_BITS;
      mag8      = (shifted > fcrq_pkg::CLAMP_MAX) ? fcrq_pkg::CLAMP_MAX[fcrq_pkg::BYTE_W-1:0]
                                                  : shifted[fcrq_pkg::BYTE_W-1:0];
      out_value = neg_ff ? -mag8 : mag8;
   end

endmodule

[rtl/fcrq_checker.sv]
// Port-level assertions for the fully connected block, bound to the top level.
module fcrq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [fcrq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // Come out of reset idle, ready and with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_tready && !rsp_tvalid))
      else $error("block not idle after reset");

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

   // The clamp never yields -128
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:0] != 8'h80))
      else $error("result outside clamp range");

   // No new item is taken while a row is still being emitted
   a_row_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> !req_tready)
      else $error("item accepted mid-row");

endmodule

bind fully_connected_int8_requant_top fcrq_checker u_fcrq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
